// ===== src/m2u_pkg.sv =====
// Shared types and codes for the multi-encoding to UTF-16 decoder.
package m2u_pkg;

	// Mode register codes
	localparam logic [2:0] MODE_UTF16LE = 3'd0;
	localparam logic [2:0] MODE_UTF8    = 3'd1;
	localparam logic [2:0] MODE_BIG5    = 3'd2;
	localparam logic [2:0] MODE_GBK     = 3'd3;
	localparam logic [2:0] MODE_JIS     = 3'd4;

	// Input command codes
	localparam logic CMD_DECODE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	// Width of the conversion table load address field
	localparam int LOAD_AW = 14;

	// What the back part does with a classified item
	typedef enum logic [1:0] {
		OP_DIRECT,
		OP_TABLE,
		OP_LOAD
	} op_kind_t;

	// Classified item passed from front to back
	typedef struct packed {
		op_kind_t             kind;
		logic [15:0]          code;
		logic [1:0]           consumed;
		logic                 valid;
		logic [6:0]           row;
		logic [7:0]           col;
		logic [7:0]           width;
		logic [LOAD_AW-1:0]   load_address;
		logic [15:0]          load_word;
	} op_t;

	// Result transaction
	typedef struct packed {
		logic [15:0] code;
		logic [1:0]  consumed;
		logic        from_table;
		logic        code_valid;
	} res_t;

endpackage

// ===== src/m2u_fifo.sv =====
// Small register queue used between front and back and on the result side.
module m2u_fifo #(
	parameter type T     = logic [7:0],
	parameter int  DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  T                           din,
	output logic                       full,
	input  logic                       pop,
	output T                           dout,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T                entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entry_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_push_only_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not grow on push");
`endif

endmodule

// ===== src/m2u_front.sv =====
// Front part: classifies an input item by command and mode into a direct result, a table lookup or a load.
module m2u_front (
	input  logic                        [2:0] mode,
	input  logic                              cmd,
	input  logic                        [7:0] first_byte,
	input  logic                        [7:0] second_byte,
	input  logic                        [7:0] third_byte,
	input  logic  [m2u_pkg::LOAD_AW-1:0]      load_address,
	input  logic                       [15:0] load_word,
	output m2u_pkg::op_t                      op
);

	// Row widths of the double-byte schemes
	localparam logic [7:0] WIDTH_BIG5 = 8'd157;
	localparam logic [7:0] WIDTH_GBK  = 8'd94;
	localparam logic [7:0] WIDTH_JIS  = 8'd188;

	logic       dbcs;
	logic       hit;
	logic [7:0] row8;
	logic [7:0] col;
	logic [7:0] width;

	// Row, column and width for the double-byte modes
	always_comb begin
		dbcs  = 1'b0;
		hit   = 1'b0;
		row8  = '0;
		col   = '0;
		width = '0;
		unique case (mode) inside
			m2u_pkg::MODE_BIG5, m2u_pkg::MODE_JIS: begin
				dbcs  = 1'b1;
				width = (mode == m2u_pkg::MODE_BIG5) ? WIDTH_BIG5 : WIDTH_JIS;
				if (first_byte >= 8'hA1 && first_byte <= 8'hC6) begin
					row8 = first_byte - 8'hA1;
					hit  = 1'b1;
				end else if (first_byte >= 8'hC9 && first_byte <= 8'hF9) begin
					row8 = first_byte - 8'hA3;
					hit  = 1'b1;
				end
				if (second_byte >= 8'h40 && second_byte <= 8'h7E) begin
					col = second_byte - 8'h40;
				end else if (second_byte >= 8'hA1 && second_byte <= 8'hFE) begin
					col = second_byte - 8'h62;
				end
			end
			m2u_pkg::MODE_GBK: begin
				dbcs  = 1'b1;
				width = WIDTH_GBK;
				if (first_byte >= 8'hA1 && first_byte <= 8'hA9) begin
					row8 = first_byte - 8'hA1;
					hit  = 1'b1;
				end else if (first_byte >= 8'hB0 && first_byte <= 8'hF7) begin
					row8 = first_byte - 8'hA6;
					hit  = 1'b1;
				end
				if (second_byte >= 8'hA1 && second_byte <= 8'hFE) begin
					col = second_byte - 8'hA1;
				end
			end
			default: begin
				dbcs = 1'b0;
			end
		endcase
	end

	// Classification
	always_comb begin
		op              = '0;
		op.kind         = m2u_pkg::OP_DIRECT;
		op.consumed     = 2'd2;
		op.valid        = 1'b1;
		op.row          = row8[6:0];
		op.col          = col;
		op.width        = width;
		op.load_address = load_address;
		op.load_word    = load_word;
		if (cmd == m2u_pkg::CMD_LOAD) begin
			op.kind = m2u_pkg::OP_LOAD;
		end else if (dbcs) begin
			if (hit) begin
				op.kind = m2u_pkg::OP_TABLE;
			end else if (first_byte < 8'h80) begin
				op.code     = {8'h00, first_byte};
				op.consumed = 2'd1;
			end else begin
				op.valid = 1'b0;
			end
		end else begin
			unique case (mode)
				m2u_pkg::MODE_UTF16LE: begin
					op.code = {second_byte, first_byte};
				end
				m2u_pkg::MODE_UTF8: begin
					if (first_byte < 8'h80) begin
						op.code     = {8'h00, first_byte};
						op.consumed = 2'd1;
					end else if (first_byte[5]) begin
						op.code     = {first_byte[3:0], second_byte[5:0], third_byte[5:0]};
						op.consumed = 2'd3;
					end else begin
						op.code = {5'b0, first_byte[4:0], second_byte[5:0]};
					end
				end
				default: begin
					op.valid = 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== src/m2u_back.sv =====
// Back part: table index, conversion table load and lookup, result assembly.
module m2u_back #(
	parameter int TABLE_DEPTH = 16384,
	parameter int OUT_DEPTH   = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  m2u_pkg::op_t                        op,
	input  logic                                op_empty,
	output logic                                op_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]      res_count,
	output logic                                res_push,
	output m2u_pkg::res_t                       res
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(OUT_DEPTH + 1);

	logic [15:0]     table_mem [TABLE_DEPTH];

	logic [CW:0]     inflight;
	logic [14:0]     index;

	logic            valid_s1;
	m2u_pkg::op_t    op_s1;
	logic [AW-1:0]   index_s1;

	logic            valid_s2;
	logic [15:0]     code_s2;
	logic [1:0]      consumed_s2;
	logic            tab_s2;
	logic            code_valid_s2;
	logic [15:0]     rdata_s2;

	// Take an item only when the result queue has room for everything in flight
	assign inflight = {1'b0, res_count} + (CW + 1)'(valid_s1) + (CW + 1)'(valid_s2);
	assign op_pop   = !op_empty && (inflight < (CW + 1)'(OUT_DEPTH));

	// Table index: row * width + col
	assign index = (15'(op.row) * 15'(op.width)) + 15'(op.col);

	// Stage 1 and stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= op_pop;
			valid_s2 <= valid_s1 && (op_s1.kind != m2u_pkg::OP_LOAD);
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_s1    <= op;
			index_s1 <= AW'(index);
		end
	end

	// Conversion table: load write or lookup read
	always_ff @(posedge clk) begin
		if (valid_s1 && op_s1.kind == m2u_pkg::OP_LOAD) begin
			table_mem[AW'(op_s1.load_address)] <= op_s1.load_word;
		end
		rdata_s2 <= table_mem[index_s1];
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			code_s2       <= op_s1.code;
			consumed_s2   <= op_s1.consumed;
			tab_s2        <= (op_s1.kind == m2u_pkg::OP_TABLE);
			code_valid_s2 <= op_s1.valid;
		end
	end

	// Result assembly
	always_comb begin
		res.code       = '0;
		res.consumed   = 2'd2;
		res.from_table = 1'b0;
		res.code_valid = code_valid_s2;
		if (code_valid_s2) begin
			res.code       = tab_s2 ? rdata_s2 : code_s2;
			res.consumed   = consumed_s2;
			res.from_table = tab_s2;
		end
	end

	assign res_push = valid_s2;

`ifndef NO_ASSERTIONS
	a_no_result_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res_count < CW'(OUT_DEPTH)))
		else $error("result pushed into a full result queue");
	a_table_result_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.from_table) |-> (res.code_valid && res.consumed == 2'd2))
		else $error("table result with wrong length or validity");
`endif

endmodule

// ===== src/multi_encoding_to_utf16_decoder_top.sv =====
// Top level of the multi-encoding to UTF-16 decoder.
//
// Input channel: an item is taken at a clock edge with push high and full low.
// cmd selects a decode of first/second/third_byte or a load of load_word into
// conversion table entry load_address. Loads give no result.
// Result channel: while empty is low the oldest result sits on code, consumed,
// from_table and code_valid; it is taken at an edge with pop high.
// Configuration: cfg_wr_en writes cfg_wr_data into the mode register; write
// only while no decode is in flight.
// Path: middle queue, stage 1, stage 2, then the result queue (empty low).
// Throughput: one item per cycle while the result side does not stall; a load
// writes the table from stage 1 and a lookup reads it at the stage 1 index.
// Reset: mode returns to UTF-8, both queues empty. The table is not cleared;
// a lookup of an entry never loaded returns an arbitrary code.
// Stall: when pop stays low, the result queue (4 deep) fills, the back part
// stops taking classified items, the 4-deep middle queue fills and full rises.
module multi_encoding_to_utf16_decoder_top #(
	parameter int TABLE_DEPTH = 16384
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              cmd,
	input  logic                        [7:0] first_byte,
	input  logic                        [7:0] second_byte,
	input  logic                        [7:0] third_byte,
	input  logic  [m2u_pkg::LOAD_AW-1:0]      load_address,
	input  logic                       [15:0] load_word,
	output logic                              empty,
	input  logic                              pop,
	output logic                       [15:0] code,
	output logic                        [1:0] consumed,
	output logic                              from_table,
	output logic                              code_valid,
	input  logic                              cfg_wr_en,
	input  logic                        [2:0] cfg_wr_data
);

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int OCW       = $clog2(OUT_DEPTH + 1);

	logic [2:0]     mode_q;
	m2u_pkg::op_t   front_op;
	m2u_pkg::op_t   mid_op;
	logic           mid_empty;
	logic           mid_pop;
	logic           res_push;
	m2u_pkg::res_t  res_in;
	m2u_pkg::res_t  res_out;
	logic [OCW-1:0] res_count;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= m2u_pkg::MODE_UTF8;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	m2u_front u_front (
		.mode         (mode_q),
		.cmd          (cmd),
		.first_byte   (first_byte),
		.second_byte  (second_byte),
		.third_byte   (third_byte),
		.load_address (load_address),
		.load_word    (load_word),
		.op           (front_op)
	);

	m2u_fifo #(
		.T     (m2u_pkg::op_t),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_op),
		.full   (full),
		.pop    (mid_pop),
		.dout   (mid_op),
		.empty  (mid_empty),
		.count  ()
	);

	m2u_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.OUT_DEPTH   (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (mid_op),
		.op_empty  (mid_empty),
		.op_pop    (mid_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res       (res_in)
	);

	m2u_fifo #(
		.T     (m2u_pkg::res_t),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty),
		.count  (res_count)
	);

	assign code       = res_out.code;
	assign consumed   = res_out.consumed;
	assign from_table = res_out.from_table;
	assign code_valid = res_out.code_valid;

endmodule
